@@ rtl/rbw_pkg.sv @@
// Shared constants and types of the radial blob warp map.
`timescale 1ns / 1ps

package rbw_pkg;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_BLOB_RANGE = 2'd0,
      CSR_STRENGTH   = 2'd1,
      CSR_INVERT     = 2'd2
   } csr_index_type;

   localparam int CSR_ADDR_W = 4;

   localparam logic [9:0] BLOB_RANGE_RESET = 10'd128;
   localparam logic [7:0] STRENGTH_RESET   = 8'd50;
   localparam logic       INVERT_RESET     = 1'b0;

   // Phase, polynomial and gain formats
   localparam int T_W   = 17;
   localparam int TT_W  = 34;
   localparam int P_W   = 29;
   localparam int PR_W  = P_W + T_W;
   localparam int COS_W = 15;
   localparam int G_W   = 32;
   localparam int DV_N  = 17;

   localparam logic [T_W-1:0] T_MAX     = 17'h10000;
   localparam logic [P_W-1:0] ONE_Q28   = 29'd268435456;
   localparam logic [P_W-1:0] C5_Q28    = 29'd6765;
   localparam logic [23:0]    KINV      = 24'd13671305;
   localparam logic [COS_W-1:0] COS_MAX = 15'd32767;

   // Horner coefficients after the innermost one, outer terms last
   localparam logic [P_W-1:0] HORNER_COEF [4] = '{
      29'd246762, 29'd5600498, 29'd68093890, 29'd331168970
   };

endpackage

@@ rtl/rbw_queue.sv @@
// Short first-in first-out queue between the front and back parts.
`timescale 1ns / 1ps

module rbw_queue #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  logic [W-1:0] wr_data,
   input  logic         rd_en,
   output logic [W-1:0] rd_data,
   output logic         empty,
   output logic         full
);
   localparam int PTR_W = $clog2(DEPTH);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_wr;
   logic             do_rd;

   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + (PTR_W+1)'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - (PTR_W+1)'(1);
         end
      end
   end

endmodule

@@ rtl/rbw_front.sv @@
// Front part: offsets from the map center, squared distance and disc test.
`timescale 1ns / 1ps

module rbw_front #(
   parameter int MAP_SIZE  = 256,
   parameter int FRAC_BITS = 8,
   parameter int OFF_W     = 17,
   parameter int D2_W      = 34
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [15:0]             coord_x,
   input  logic [15:0]             coord_y,
   input  logic [8:0]              radius,
   input  logic                    q_full,
   output logic                    q_push,
   output logic [15:0]             q_px,
   output logic [15:0]             q_py,
   output logic signed [OFF_W-1:0] q_dx,
   output logic signed [OFF_W-1:0] q_dy,
   output logic [D2_W-1:0]         q_d2,
   output logic                    q_pass
);
   import rbw_pkg::*;

   localparam int RQ_W  = 9 + FRAC_BITS;
   localparam int RS_W  = 2 * RQ_W;
   localparam int CMP_W = (D2_W > RS_W) ? D2_W : RS_W;
   localparam logic signed [OFF_W-1:0] CENTER = OFF_W'((MAP_SIZE / 2) << FRAC_BITS);

   logic                    adv;
   logic                    a_v_ff;
   logic [15:0]             a_px_ff, a_py_ff;
   logic signed [OFF_W-1:0] a_dx_ff, a_dy_ff;
   logic                    b_v_ff;
   logic [15:0]             b_px_ff, b_py_ff;
   logic signed [OFF_W-1:0] b_dx_ff, b_dy_ff;
   logic [D2_W-1:0]         b_sqx_ff, b_sqy_ff;
   logic [RS_W-1:0]         rq_sq_ff;
   logic [RQ_W-1:0]         rq;

   // Hold every stage while the queue is full
   assign adv  = !q_full;
   assign full = q_full;
   assign rq   = {radius, FRAC_BITS'(0)};

   always_ff @(posedge clock) begin
      rq_sq_ff <= RS_W'(rq) * RS_W'(rq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= push;
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_px_ff  <= coord_x;
         a_py_ff  <= coord_y;
         a_dx_ff  <= signed'(OFF_W'(coord_x)) - CENTER;
         a_dy_ff  <= signed'(OFF_W'(coord_y)) - CENTER;
         b_px_ff  <= a_px_ff;
         b_py_ff  <= a_py_ff;
         b_dx_ff  <= a_dx_ff;
         b_dy_ff  <= a_dy_ff;
         b_sqx_ff <= D2_W'(D2_W'(a_dx_ff) * D2_W'(a_dx_ff));
         b_sqy_ff <= D2_W'(D2_W'(a_dy_ff) * D2_W'(a_dy_ff));
      end
   end

   always_comb begin
      q_push = b_v_ff && adv;
      q_px   = b_px_ff;
      q_py   = b_py_ff;
      q_dx   = b_dx_ff;
      q_dy   = b_dy_ff;
      q_d2   = b_sqx_ff + b_sqy_ff;
      q_pass = (radius == '0) || (CMP_W'(q_d2) > CMP_W'(rq_sq_ff));
   end

endmodule

@@ rtl/rbw_back.sv @@
// Back part: square root, phase divide, cosine, gain and displacement.
`timescale 1ns / 1ps

module rbw_back #(
   parameter int MAP_SIZE  = 256,
   parameter int FRAC_BITS = 8,
   parameter int OFF_W     = 17,
   parameter int D2_W      = 34
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  logic [15:0]             q_px,
   input  logic [15:0]             q_py,
   input  logic signed [OFF_W-1:0] q_dx,
   input  logic signed [OFF_W-1:0] q_dy,
   input  logic [D2_W-1:0]         q_d2,
   input  logic                    q_pass,
   input  logic [8:0]              radius,
   input  logic [7:0]              strength,
   input  logic                    invert,
   output logic                    empty,
   input  logic                    pop,
   output logic [15:0]             warped_x,
   output logic [15:0]             warped_y
);
   import rbw_pkg::*;

   localparam int SQ_W = OFF_W;
   localparam int TW   = 2 * SQ_W + 1;
   localparam int RQ_W = 9 + FRAC_BITS;
   localparam int RM_W = RQ_W + 1;
   localparam int MP_W = OFF_W + G_W;
   localparam int M_W  = OFF_W + 1;
   localparam int NW   = OFF_W + 3;
   localparam int L    = SQ_W + DV_N + 11;
   localparam int I_G0 = L - 4;
   localparam int I_M0 = L - 3;
   localparam int I_M1 = L - 2;
   localparam logic signed [NW-1:0] LIM = NW'((MAP_SIZE - 1) << FRAC_BITS);

   logic                    adv;
   logic [L-1:0]            valid_ff;
   logic [15:0]             sd_px_ff   [L];
   logic [15:0]             sd_py_ff   [L];
   logic signed [OFF_W-1:0] sd_dx_ff   [L];
   logic signed [OFF_W-1:0] sd_dy_ff   [L];
   logic                    sd_pass_ff [L];

   logic [TW-1:0]   sq_rem_ff  [SQ_W];
   logic [SQ_W-1:0] sq_root_ff [SQ_W];
   logic [RM_W-1:0] dv_rem_ff  [DV_N];
   logic [T_W-1:0]  dv_q_ff    [DV_N];
   logic [RM_W-1:0] rqx;

   logic [TT_W-1:0]  tt_ff;
   logic [T_W-1:0]   u_ff  [5];
   logic [PR_W-1:0]  pr_ff [5];
   logic [COS_W-1:0] c_ff;
   logic [31:0]      skinv_ff;
   logic [G_W-1:0]   g_ff;
   logic [MP_W-1:0]  mpx_ff, mpy_ff;
   logic signed [NW-1:0] nx_ff, ny_ff;
   logic [15:0]      out_x_ff, out_y_ff;

   logic [T_W-1:0]   t_w;
   logic [T_W-1:0]   u_w;
   logic signed [31:0] v_w;
   logic [16:0]      cr_w;
   logic [COS_W-1:0] c_w;
   logic [OFF_W-1:0] magx_w, magy_w;
   logic [M_W-1:0]   mx_w, my_w;
   logic signed [NW-1:0] dlx_w, dly_w, pxs_w, pys_w;
   logic             in_map_w;

   // Advance the whole pipeline whenever the result slot frees up
   assign adv      = !valid_ff[L-1] || pop;
   assign q_pop    = adv && !q_empty;
   assign empty    = !valid_ff[L-1];
   assign warped_x = out_x_ff;
   assign warped_y = out_y_ff;
   assign rqx      = RM_W'({radius, FRAC_BITS'(0)});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[L-2:0], !q_empty};
      end
   end

   always_ff @(posedge clock) begin
      skinv_ff <= 32'(strength) * 32'(KINV);
      if (adv) begin
         sd_px_ff[0]   <= q_px;
         sd_py_ff[0]   <= q_py;
         sd_dx_ff[0]   <= q_dx;
         sd_dy_ff[0]   <= q_dy;
         sd_pass_ff[0] <= q_pass;
         for (int i = 1; i < L; i++) begin
            sd_px_ff[i]   <= sd_px_ff[i-1];
            sd_py_ff[i]   <= sd_py_ff[i-1];
            sd_dx_ff[i]   <= sd_dx_ff[i-1];
            sd_dy_ff[i]   <= sd_dy_ff[i-1];
            sd_pass_ff[i] <= sd_pass_ff[i-1];
         end
      end
   end

   // Square root, one root bit per stage
   for (genvar j = 0; j < SQ_W; j++) begin : g_sqrt
      localparam int K = SQ_W - 1 - j;
      logic [TW-1:0]   rem_w;
      logic [SQ_W-1:0] root_w;
      logic [TW-1:0]   trial_w;
      if (j == 0) begin : g_first
         assign rem_w  = TW'(q_d2);
         assign root_w = '0;
      end else begin : g_next
         assign rem_w  = sq_rem_ff[j-1];
         assign root_w = sq_root_ff[j-1];
      end
      assign trial_w = (TW'(root_w) << (K + 1)) + (TW'(1) << (2 * K));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rem_w >= trial_w) begin
               sq_rem_ff[j]  <= rem_w - trial_w;
               sq_root_ff[j] <= root_w | (SQ_W'(1) << K);
            end else begin
               sq_rem_ff[j]  <= rem_w;
               sq_root_ff[j] <= root_w;
            end
         end
      end
   end

   // Phase divide, one quotient bit per stage
   for (genvar j = 0; j < DV_N; j++) begin : g_div
      logic [RM_W-1:0] r_w;
      logic [T_W-1:0]  q_w;
      if (j == 0) begin : g_first
         assign r_w = RM_W'(sq_root_ff[SQ_W-1]);
         assign q_w = '0;
      end else begin : g_next
         assign r_w = {dv_rem_ff[j-1][RM_W-2:0], 1'b0};
         assign q_w = dv_q_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (r_w >= rqx) begin
               dv_rem_ff[j] <= r_w - rqx;
               dv_q_ff[j]   <= {q_w[T_W-2:0], 1'b1};
            end else begin
               dv_rem_ff[j] <= r_w;
               dv_q_ff[j]   <= {q_w[T_W-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      t_w = (dv_q_ff[DV_N-1] > T_MAX) ? T_MAX : dv_q_ff[DV_N-1];
      u_w = tt_ff[T_W+15:16];
      v_w = signed'(32'(ONE_Q28)) - signed'(32'(pr_ff[4] >> 16));
      if (v_w < 0) begin
         v_w = '0;
      end
      cr_w = 17'((v_w + 32'sd4096) >>> 13);
      c_w  = (cr_w > 17'(COS_MAX)) ? COS_MAX : cr_w[COS_W-1:0];
      magx_w = sd_dx_ff[I_G0][OFF_W-1] ? OFF_W'(-sd_dx_ff[I_G0]) : OFF_W'(sd_dx_ff[I_G0]);
      magy_w = sd_dy_ff[I_G0][OFF_W-1] ? OFF_W'(-sd_dy_ff[I_G0]) : OFF_W'(sd_dy_ff[I_G0]);
      mx_w = M_W'(((MP_W+1)'(mpx_ff) + (MP_W+1)'(33'h080000000)) >> 32);
      my_w = M_W'(((MP_W+1)'(mpy_ff) + (MP_W+1)'(33'h080000000)) >> 32);
      // The move takes the sign of the offset
      dlx_w = sd_dx_ff[I_M0][OFF_W-1] ? -signed'(NW'(mx_w)) : signed'(NW'(mx_w));
      dly_w = sd_dy_ff[I_M0][OFF_W-1] ? -signed'(NW'(my_w)) : signed'(NW'(my_w));
      pxs_w = signed'(NW'(sd_px_ff[I_M0]));
      pys_w = signed'(NW'(sd_py_ff[I_M0]));
      in_map_w = (nx_ff > 0) && (ny_ff > 0) && (nx_ff < LIM) && (ny_ff < LIM);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tt_ff    <= TT_W'(t_w) * TT_W'(t_w);
         u_ff[0]  <= u_w;
         pr_ff[0] <= PR_W'(C5_Q28) * PR_W'(u_w);
         for (int k = 1; k < 5; k++) begin
            u_ff[k]  <= u_ff[k-1];
            pr_ff[k] <= PR_W'(P_W'(HORNER_COEF[k-1] - P_W'(pr_ff[k-1] >> 16)))
                        * PR_W'(u_ff[k-1]);
         end
         c_ff   <= c_w;
         g_ff   <= G_W'((47'(skinv_ff) * 47'(c_ff)) >> 15);
         mpx_ff <= MP_W'(magx_w) * MP_W'(g_ff);
         mpy_ff <= MP_W'(magy_w) * MP_W'(g_ff);
         nx_ff  <= invert ? pxs_w + dlx_w : pxs_w - dlx_w;
         ny_ff  <= invert ? pys_w + dly_w : pys_w - dly_w;
         // Drop the move when outside the disc or when it leaves the map
         if (sd_pass_ff[I_M1] || !in_map_w) begin
            out_x_ff <= sd_px_ff[I_M1];
            out_y_ff <= sd_py_ff[I_M1];
         end else begin
            out_x_ff <= nx_ff[15:0];
            out_y_ff <= ny_ff[15:0];
         end
      end
   end

endmodule

@@ rtl/radial_blob_warp_map.sv @@
// Top level of the radial pinch and bulge warp of coordinate-map entries.
`timescale 1ns / 1ps

// Radial blob warp map: each request is one map entry (x, y) in unsigned
// fixed point; the result is the entry pushed away from (bulge) or pulled
// toward (pinch) the map center by strength/(100*pi) * cos(d*pi/(2R)) of its
// offset, when it lies in the disc of radius R = blob_range/2 and the moved
// point stays strictly inside the map; otherwise the entry passes through.
// One request is taken every clock while full is low, and one result leaves
// every clock while results are popped. The front part computes the offsets,
// the squared distance and the disc test, then a four-entry queue decouples
// it from the back part, whose pipeline is OFF_W + 28 stages deep (45 at the
// default 256-entry map with eight fraction bits): OFF_W stages of the
// bit-per-stage square root, 17 of the bit-per-stage phase divider, then
// cosine, gain and displacement. The back part stalls as a whole only while
// its result is not taken. Write the registers through the APB port while no request is in flight.

module radial_blob_warp_map #(
   parameter int MAP_SIZE  = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        push,
   output logic        full,
   input  logic [15:0] req_coord_x,
   input  logic [15:0] req_coord_y,
   // result side
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_warped_x,
   output logic [15:0] rsp_warped_y,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [rbw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rbw_pkg::*;

   // Offsets are signed and wide enough for both the center and a 16-bit input
   localparam int CEN_W = $clog2(MAP_SIZE) + FRAC_BITS;
   localparam int OFF_W = ((CEN_W > 16) ? CEN_W : 16) + 1;
   localparam int D2_W  = 2 * OFF_W;
   localparam int E_W   = 32 + 2 * OFF_W + D2_W + 1;

   logic [9:0]    blob_range_ff;
   logic [7:0]    strength_ff;
   logic          invert_ff;
   csr_index_type csr_idx;
   logic          csr_wr;

   logic                    q_full, q_empty, q_push, q_pop, q_pass_w, q_pass_r;
   logic [15:0]             q_px_w, q_py_w, q_px_r, q_py_r;
   logic signed [OFF_W-1:0] q_dx_w, q_dy_w, q_dx_r, q_dy_r;
   logic [D2_W-1:0]         q_d2_w, q_d2_r;
   logic [E_W-1:0]          q_wdata, q_rdata;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   // Register writes; an address past the last register is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         blob_range_ff <= BLOB_RANGE_RESET;
         strength_ff   <= STRENGTH_RESET;
         invert_ff     <= INVERT_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_BLOB_RANGE: blob_range_ff <= pwdata[9:0];
            CSR_STRENGTH:   strength_ff   <= pwdata[7:0];
            CSR_INVERT:     invert_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_BLOB_RANGE: prdata = 32'(blob_range_ff);
         CSR_STRENGTH:   prdata = 32'(strength_ff);
         CSR_INVERT:     prdata = 32'(invert_ff);
         default:        prdata = '0;
      endcase
   end

   rbw_front #(
      .MAP_SIZE  (MAP_SIZE),
      .FRAC_BITS (FRAC_BITS),
      .OFF_W     (OFF_W),
      .D2_W      (D2_W)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .coord_x (req_coord_x),
      .coord_y (req_coord_y),
      .radius  (blob_range_ff[9:1]),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_px    (q_px_w),
      .q_py    (q_py_w),
      .q_dx    (q_dx_w),
      .q_dy    (q_dy_w),
      .q_d2    (q_d2_w),
      .q_pass  (q_pass_w)
   );

   // Pack the classified request into one queue word
   assign q_wdata = {q_px_w, q_py_w, q_dx_w, q_dy_w, q_d2_w, q_pass_w};
   assign {q_px_r, q_py_r, q_dx_r, q_dy_r, q_d2_r, q_pass_r} = q_rdata;

   rbw_queue #(
      .W     (E_W),
      .DEPTH (4)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wdata),
      .rd_en   (q_pop),
      .rd_data (q_rdata),
      .empty   (q_empty),
      .full    (q_full)
   );

   rbw_back #(
      .MAP_SIZE  (MAP_SIZE),
      .FRAC_BITS (FRAC_BITS),
      .OFF_W     (OFF_W),
      .D2_W      (D2_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_px     (q_px_r),
      .q_py     (q_py_r),
      .q_dx     (q_dx_r),
      .q_dy     (q_dy_r),
      .q_d2     (q_d2_r),
      .q_pass   (q_pass_r),
      .radius   (blob_range_ff[9:1]),
      .strength (strength_ff),
      .invert   (invert_ff),
      .empty    (empty),
      .pop      (pop),
      .warped_x (rsp_warped_x),
      .warped_y (rsp_warped_y)
   );

endmodule
